// File: rtl/dts_pkg.sv
package dts_pkg;

    localparam int SCORE_BITS       = 7;
    localparam int CLASS_BITS       = 2;
    localparam int TARGET_CLS_BITS  = 2;
    localparam int COORD_BITS_DEF   = 10;

    localparam logic [SCORE_BITS-1:0] THRESHOLD_RESET = 7'd25;

    // detection class on the input side
    localparam logic [CLASS_BITS-1:0] CLS_FACE   = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLS_PERSON = 2'd1;

    // target class on the output side
    localparam logic [TARGET_CLS_BITS-1:0] TGT_NONE   = 2'd0;
    localparam logic [TARGET_CLS_BITS-1:0] TGT_FACE   = 2'd1;
    localparam logic [TARGET_CLS_BITS-1:0] TGT_PERSON = 2'd2;

endpackage

// File: rtl/detection_target_selector.sv
// Detection target selector.
//
// Slave stream: one detection per request. s_tuser carries the class
// (face, person, anything else ignored), s_tdata the score and box, and
// s_tlast closes the frame. The largest face and the highest-scoring person
// are kept across the frame; ties keep the earlier one.
// Master stream: one result per frame, emitted for the request carrying
// s_tlast. m_tuser flags whether a target was found and its class; m_tdata
// holds the box, centre, confidence and area (all zero when none found).
// cfg: write channel for the score threshold, always ready; write it only
// while no frame is in flight.
// Result path: the closing request is captured in the input register and
// moves on to the result register once that register has room.
// Throughput: one request per cycle while the result register has room for
// a frame end; each request is compared combinationally against the stored
// bests, the box area being multiplied on the way into the input register.
// Reset clears the stored bests, empties both registers and sets the
// threshold to 25. When the receiver stalls, the result is held and
// detections keep flowing; a further frame end waits in the input
// register until the result has been taken.
module detection_target_selector #(
    parameter int COORD_BITS = dts_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // score, x, y, w, h (from bit 0 up), zero padded to whole bytes
    input  logic [((dts_pkg::SCORE_BITS + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // object_class
    input  logic [dts_pkg::CLASS_BITS-1:0] s_tuser,
    input  logic s_tlast,

    output logic m_tvalid,
    input  logic m_tready,
    // target_x, target_y, target_w, target_h, center_x, center_y,
    // confidence, area (from bit 0 up), zero padded to whole bytes
    output logic [((8*COORD_BITS + dts_pkg::SCORE_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    // target_found, target_class
    output logic [dts_pkg::TARGET_CLS_BITS:0] m_tuser,

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [dts_pkg::SCORE_BITS-1:0] cfg_data
);

    localparam int SB      = dts_pkg::SCORE_BITS;
    localparam int CB      = COORD_BITS;
    localparam int AB      = 2 * COORD_BITS;
    localparam int OUT_USED = 8*CB + SB + 2;
    localparam int OUT_W   = ((OUT_USED + 7) / 8) * 8;

    typedef struct packed {
        logic [SB-1:0] score;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
        logic [AB-1:0] area;
    } det_rec_t;

    // input register
    logic                          in_valid_reg;
    logic [dts_pkg::CLASS_BITS-1:0] in_cls_reg;
    det_rec_t                      in_rec_reg;
    logic                          in_last_reg;
    det_rec_t                      s_rec;

    // stored bests
    logic     face_seen_reg, face_seen_next;
    det_rec_t face_reg, face_next;
    logic     person_seen_reg, person_seen_next;
    det_rec_t person_reg, person_next;

    logic [SB-1:0] threshold_reg;

    // result register
    logic                               out_valid_reg;
    logic                               out_found_reg, out_found_next;
    logic [dts_pkg::TARGET_CLS_BITS-1:0] out_cls_reg, out_cls_next;
    logic [OUT_W-1:0]                   out_data_reg, out_data_next;

    logic     out_free;
    logic     proc;
    logic     face_take;
    logic     person_take;
    logic     face_ok;
    logic     person_ok;
    det_rec_t chosen;
    logic [CB:0] cx;
    logic [CB:0] cy;

    assign s_rec.score = s_tdata[SB-1:0];
    assign s_rec.x     = s_tdata[SB        +: CB];
    assign s_rec.y     = s_tdata[SB + CB   +: CB];
    assign s_rec.w     = s_tdata[SB + 2*CB +: CB];
    assign s_rec.h     = s_tdata[SB + 3*CB +: CB];
    assign s_rec.area  = AB'(s_rec.w) * AB'(s_rec.h);

    assign out_free  = !out_valid_reg || m_tready;
    // a frame end needs room in the result register, other requests never wait
    assign proc      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_cls_reg, out_found_reg};

    always_comb
    begin
        face_take   = (in_cls_reg == dts_pkg::CLS_FACE) &&
                      (!face_seen_reg || in_rec_reg.area > face_reg.area);
        person_take = (in_cls_reg == dts_pkg::CLS_PERSON) &&
                      (!person_seen_reg || in_rec_reg.score > person_reg.score);

        face_seen_next   = face_seen_reg || face_take;
        face_next        = face_take ? in_rec_reg : face_reg;
        person_seen_next = person_seen_reg || person_take;
        person_next      = person_take ? in_rec_reg : person_reg;

        face_ok   = face_seen_next && (face_next.score >= threshold_reg);
        person_ok = person_seen_next && (person_next.score >= threshold_reg);

        if (face_ok)
        begin
            chosen       = face_next;
            out_found_next = 1'b1;
            out_cls_next = dts_pkg::TGT_FACE;
        end
        else if (person_ok)
        begin
            chosen       = person_next;
            out_found_next = 1'b1;
            out_cls_next = dts_pkg::TGT_PERSON;
        end
        else
        begin
            chosen       = '0;
            out_found_next = 1'b0;
            out_cls_next = dts_pkg::TGT_NONE;
        end

        cx = {1'b0, chosen.x} + {2'b00, chosen.w[CB-1:1]};
        cy = {1'b0, chosen.y} + {2'b00, chosen.h[CB-1:1]};

        out_data_next = '0;
        out_data_next[0      +: CB]     = chosen.x;
        out_data_next[CB     +: CB]     = chosen.y;
        out_data_next[2*CB   +: CB]     = chosen.w;
        out_data_next[3*CB   +: CB]     = chosen.h;
        out_data_next[4*CB   +: CB + 1] = cx;
        out_data_next[5*CB+1 +: CB + 1] = cy;
        out_data_next[6*CB+2 +: SB]     = chosen.score;
        out_data_next[6*CB+2+SB +: AB]  = chosen.area;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cls_reg  <= s_tuser;
            in_rec_reg  <= s_rec;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_seen_reg   <= 1'b0;
            face_reg        <= '0;
            person_seen_reg <= 1'b0;
            person_reg      <= '0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                face_seen_reg   <= 1'b0;
                face_reg        <= '0;
                person_seen_reg <= 1'b0;
                person_reg      <= '0;
            end
            else
            begin
                face_seen_reg   <= face_seen_next;
                face_reg        <= face_next;
                person_seen_reg <= person_seen_next;
                person_reg      <= person_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= dts_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            out_found_reg <= out_found_next;
            out_cls_reg   <= out_cls_next;
            out_data_reg  <= out_data_next;
        end
    end

    // a fresh result only follows a processed frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(proc && in_last_reg))
        else $error("result without frame end");

    // bests are empty after a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> (!face_seen_reg && !person_seen_reg))
        else $error("bests not cleared after frame end");

    // a found target passes the threshold and has a class
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |->
        ((out_data_reg[6*CB+2 +: SB] >= threshold_reg) &&
         (out_cls_reg != dts_pkg::TGT_NONE)))
        else $error("found target below threshold or without class");

    // no target means an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |->
        ((out_data_reg == '0) && (out_cls_reg == dts_pkg::TGT_NONE)))
        else $error("empty result not zero");

endmodule
